FILE: rtl/core/hdlc_frame_receiver_defines.svh
// assertion macros shared by the frame receiver
`ifndef HDLC_FRAME_RECEIVER_DEFINES_SVH
`define HDLC_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hfr_pkg.sv
// types, codes and the crc step of the frame receiver
package hfr_pkg;

  localparam int CntW = 9;
  localparam int CrcW = 16;

  localparam logic [7:0]      FlagByte = 8'h7e;
  localparam logic [7:0]      EscByte  = 8'h7d;
  localparam logic [7:0]      EscXor   = 8'h20;
  localparam logic [CrcW-1:0] CrcStart = 16'hffff;
  localparam logic [CrcW-1:0] PolyRst  = 16'h1021;
  localparam logic [CntW-1:0] LenRst   = 9'd256;

  // configuration register indexes
  localparam logic CfgPoly   = 1'b0;
  localparam logic CfgMaxLen = 1'b1;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_DATA = 2'd2
  } hfr_mode_e;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_BADCRC   = 2'd2,
    EV_OVERFLOW = 2'd3
  } hfr_kind_e;

  // decision for one byte, from the decoder to the state and result registers
  typedef struct packed {
    logic            emit;
    hfr_kind_e       kind;
    logic [7:0]      value;
    logic [7:0]      index;
    logic [CntW-1:0] length;
    logic            cnt_clr;
    logic            cnt_inc;
    logic            crc_load;
    logic            crc_upd;
  } hfr_step_t;

  // msb-first crc over one byte
  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
                                               input logic [7:0]      b,
                                               input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/hdlc_frame_receiver.sv
// byte-stuffed frame receiver with crc-16 check, top level
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_stall_o   rx_byte_i, restart_i
//   out      from block out_valid_o/out_stall_i event_kind_o, byte_value_o,
//                                               byte_index_o, frame_length_o
//   cfg      to block   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one byte per cycle while the input register is not stalled: a request is captured
// in the input register, and the decode plus one 8-step crc fold settle before the
// state and result registers; bytes that give no result (hunt bytes, flags that
// open, escapes) only update the state.
// reset is asynchronous: hunt mode, count zero, crc 0xffff, registers at default.
// a held result stalls the input register only when its byte also has a result.
`include "hdlc_frame_receiver_defines.svh"

module hdlc_frame_receiver #(
  parameter int MAX_FRAME = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input bytes
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       restart_i,
  // result events
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 event_kind_o,
  output logic [7:0]                 byte_value_o,
  output logic [7:0]                 byte_index_o,
  output logic [hfr_pkg::CntW-1:0]   frame_length_o,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [hfr_pkg::CrcW-1:0]   cfg_wdata_i
);

  localparam int CntMax = (1 << hfr_pkg::CntW) - 1;
  localparam int CapInt = (MAX_FRAME > CntMax) ? CntMax : MAX_FRAME;
  localparam logic [hfr_pkg::CntW-1:0] LimitCap = hfr_pkg::CntW'(CapInt);

  logic [hfr_pkg::CrcW-1:0] poly_q;
  logic [hfr_pkg::CntW-1:0] max_len_q;
  logic [hfr_pkg::CntW-1:0] limit;

  hfr_pkg::hfr_mode_e       mode_q, mode_d;
  logic [hfr_pkg::CntW-1:0] count_q, count_d;
  logic [hfr_pkg::CrcW-1:0] crc_q, crc_d;

  logic                     in_vld_q;
  logic [7:0]               in_byte_q;
  logic                     in_restart_q;

  logic                     out_vld_q;
  hfr_pkg::hfr_kind_e       out_kind_q;
  logic [7:0]               out_value_q;
  logic [7:0]               out_index_q;
  logic [hfr_pkg::CntW-1:0] out_len_q;

  hfr_pkg::hfr_step_t       step;
  logic                     out_free;
  logic                     advance;
  logic                     in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    <= hfr_pkg::PolyRst;
      max_len_q <= hfr_pkg::LenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hfr_pkg::CfgPoly:   poly_q    <= cfg_wdata_i;
        hfr_pkg::CfgMaxLen: max_len_q <= cfg_wdata_i[hfr_pkg::CntW-1:0];
        default:            poly_q    <= poly_q;
      endcase
    end
  end

  // length limit clamped to the build-time maximum
  assign limit = (max_len_q > LimitCap) ? LimitCap : max_len_q;

  // deframing decision for the registered byte
  hfr_decode u_decode (
    .mode_i      (mode_q),
    .rx_byte_i   (in_byte_q),
    .restart_i   (in_restart_q),
    .count_i     (count_q),
    .crc_i       (crc_q),
    .limit_i     (limit),
    .mode_next_o (mode_d),
    .step_o      (step)
  );

  // handshake between input register and result register
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!step.emit || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // count and crc updates
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (step.cnt_clr) begin
      count_d = '0;
    end else if (step.cnt_inc) begin
      count_d = count_q + 1'b1;
    end
    if (step.crc_load) begin
      crc_d = hfr_pkg::CrcStart;
    end else if (step.crc_upd) begin
      crc_d = hfr_pkg::crc_fold(crc_q, step.value, poly_q);
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= hfr_pkg::MODE_HUNT;
      count_q <= '0;
      crc_q   <= hfr_pkg::CrcStart;
    end else if (advance) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= rx_byte_i;
      in_restart_q <= restart_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && step.emit;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (out_free && advance && step.emit) begin
      out_kind_q  <= step.kind;
      out_value_q <= step.value;
      out_index_q <= step.index;
      out_len_q   <= step.length;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_kind_o   = out_kind_q;
  assign byte_value_o   = out_value_q;
  assign byte_index_o   = out_index_q;
  assign frame_length_o = out_len_q;

  // checks
  `HFR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o,
                  in_vld_q && out_vld_q && out_stall_i, "input stalled without a held result")
  `HFR_ASSERT_NXT(a_count_step, clk_i, rst_ni,
                  advance && step.emit && (step.kind == hfr_pkg::EV_DATA),
                  count_q == $past(count_q) + 1'b1, "data byte did not advance the count")
  `HFR_ASSERT_NXT(a_end_hunt, clk_i, rst_ni,
                  advance && step.emit && (step.kind != hfr_pkg::EV_DATA),
                  mode_q == hfr_pkg::MODE_HUNT, "frame end did not return to hunt")

endmodule

FILE: rtl/core/hfr_decode.sv
// per-byte deframing decision: next mode, event and counter/crc controls
module hfr_decode (
  input  hfr_pkg::hfr_mode_e                mode_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              restart_i,
  input  logic [hfr_pkg::CntW-1:0]          count_i,
  input  logic [hfr_pkg::CrcW-1:0]          crc_i,
  input  logic [hfr_pkg::CntW-1:0]          limit_i,
  output hfr_pkg::hfr_mode_e                mode_next_o,
  output hfr_pkg::hfr_step_t                step_o
);

  hfr_pkg::hfr_mode_e mode_eff;
  logic               is_flag;
  logic               is_esc;
  logic               full;

  // restart forces hunt before the byte is looked at
  assign mode_eff = restart_i ? hfr_pkg::MODE_HUNT : mode_i;
  assign is_flag  = (rx_byte_i == hfr_pkg::FlagByte);
  assign is_esc   = (rx_byte_i == hfr_pkg::EscByte);
  assign full     = (count_i >= limit_i);

  // next mode
  always_comb begin
    unique case (mode_eff)
      hfr_pkg::MODE_ESC: begin
        mode_next_o = full ? hfr_pkg::MODE_HUNT : hfr_pkg::MODE_DATA;
      end
      hfr_pkg::MODE_DATA: begin
        priority if (is_flag) begin
          mode_next_o = hfr_pkg::MODE_HUNT;
        end else if (is_esc) begin
          mode_next_o = hfr_pkg::MODE_ESC;
        end else begin
          mode_next_o = full ? hfr_pkg::MODE_HUNT : hfr_pkg::MODE_DATA;
        end
      end
      default: begin
        // hunt, and the unused code
        mode_next_o = is_flag ? hfr_pkg::MODE_DATA : hfr_pkg::MODE_HUNT;
      end
    endcase
  end

  // event and state controls
  always_comb begin
    logic       store;
    logic [7:0] sval;
    step_o = '0;
    step_o.kind = hfr_pkg::EV_DATA;
    store = 1'b0;
    sval  = rx_byte_i;
    unique case (mode_eff)
      hfr_pkg::MODE_ESC: begin
        store = 1'b1;
        sval  = rx_byte_i ^ hfr_pkg::EscXor;
      end
      hfr_pkg::MODE_DATA: begin
        priority if (is_flag) begin
          step_o.emit   = 1'b1;
          step_o.kind   = (crc_i == '0) ? hfr_pkg::EV_GOOD : hfr_pkg::EV_BADCRC;
          step_o.length = count_i;
        end else if (is_esc) begin
          store = 1'b0;
        end else begin
          store = 1'b1;
        end
      end
      default: begin
        // opening flag clears the frame state
        step_o.cnt_clr  = is_flag;
        step_o.crc_load = is_flag;
      end
    endcase

    // store one unstuffed byte, or abort when the frame is full
    if (store) begin
      step_o.emit = 1'b1;
      if (full) begin
        step_o.kind   = hfr_pkg::EV_OVERFLOW;
        step_o.length = count_i;
      end else begin
        step_o.kind    = hfr_pkg::EV_DATA;
        step_o.value   = sval;
        step_o.index   = count_i[7:0];
        step_o.cnt_inc = 1'b1;
        step_o.crc_upd = 1'b1;
      end
    end
  end

endmodule
